// ===== sv/nfsp_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the next-fit slot pool with aging.
// Used by nfsp_cell and the top level; depends on nothing else.
package nfsp_pkg;

    localparam int SLOTS       = 64;
    localparam int IDX_W       = $clog2(SLOTS);
    localparam int OUT_IDX_W   = 6;
    localparam int LIFE_W      = 16;
    localparam int RATE_W      = 16;
    localparam int TIME_W      = 16;
    localparam int PROD_W      = RATE_W + TIME_W;
    localparam int DEC_SHIFT   = 8;
    localparam int DEC_W       = PROD_W - DEC_SHIFT;

    localparam logic [LIFE_W-1:0] LIFE_FULL   = '1;
    localparam logic [RATE_W-1:0] DECAY_RESET = RATE_W'(256);

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic              alloc_en;
        logic              tick_en;
        logic [DEC_W-1:0]  dec;
    } cell_ctl_t;

endpackage

// ===== sv/nfsp_cell.sv =====
`timescale 1ns / 1ps
// One slot of the pool: holds its life value, ages it on a tick and takes
// part in the two-pass free-slot search chain. Depends on nfsp_pkg.
module nfsp_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  nfsp_pkg::cell_ctl_t  ctl,
    input  logic                 grant,
    input  logic                 ge_start,
    input  logic                 found_a_in,
    input  logic                 found_b_in,
    output logic                 found_a_out,
    output logic                 found_b_out,
    output logic                 hit_a,
    output logic                 hit_b
);

    logic [nfsp_pkg::LIFE_W-1:0] life_reg;
    logic [nfsp_pkg::LIFE_W-1:0] life_next;
    logic                        free;
    logic                        above_dec;

    assign free = (life_reg == '0);

    // Pass A covers slots at or after the start index, pass B the ones below it
    assign hit_a       = free & ge_start & ~found_a_in;
    assign found_a_out = found_a_in | (free & ge_start);
    assign hit_b       = free & ~ge_start & ~found_b_in;
    assign found_b_out = found_b_in | (free & ~ge_start);

    assign above_dec = (nfsp_pkg::DEC_W'(life_reg) > ctl.dec);

    always_comb
    begin
        life_next = life_reg;
        if (ctl.alloc_en && grant)
        begin
            life_next = nfsp_pkg::LIFE_FULL;
        end
        else if (ctl.tick_en)
        begin
            // Saturate at zero; when above, the decrement fits in LIFE_W bits
            life_next = above_dec ? (life_reg - ctl.dec[nfsp_pkg::LIFE_W-1:0]) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            life_reg <= '0;
        end
        else
        begin
            life_reg <= life_next;
        end
    end

endmodule

// ===== sv/next_fit_slot_pool_with_aging.sv =====
`timescale 1ns / 1ps
// Next-fit slot pool with aging: a row of nfsp_cell slots, search and tick control.
// Every request holds busy high for 1 cycle after the accept edge (grant or tick state);
// no new request is taken while busy. An allocate result strobes done for one
// cycle, registered from the grant state; a tick gives no result. The receiver cannot stall.
// Reset clears all slots to free, the search start to 0 and decay_rate to 256.
module next_fit_slot_pool_with_aging (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               req_type,
    input  logic [nfsp_pkg::TIME_W-1:0]        tick_time,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [nfsp_pkg::RATE_W-1:0]        cfg_data,
    output logic                               done,
    output logic [nfsp_pkg::OUT_IDX_W-1:0]     slot_index,
    output logic                               overwrote_live
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_GRANT = 2'd1;
    localparam logic [1:0] ST_TICK  = 2'd2;

    logic [1:0]                          state_reg;
    logic [1:0]                          state_next;
    logic [nfsp_pkg::RATE_W-1:0]         decay_rate_reg;
    logic [nfsp_pkg::IDX_W-1:0]          search_start_reg;
    logic [nfsp_pkg::SLOTS-1:0]          grant_reg;
    logic [nfsp_pkg::SLOTS-1:0]          grant_next;
    logic                                over_reg;
    logic                                over_next;
    logic [nfsp_pkg::DEC_W-1:0]          dec_reg;
    logic [nfsp_pkg::PROD_W-1:0]         product;
    logic                                done_reg;
    logic [nfsp_pkg::OUT_IDX_W-1:0]      slot_index_reg;
    logic                                overwrote_reg;
    logic                                accept;
    logic [nfsp_pkg::SLOTS:0]            found_a;
    logic [nfsp_pkg::SLOTS:0]            found_b;
    logic [nfsp_pkg::SLOTS-1:0]          hit_a;
    logic [nfsp_pkg::SLOTS-1:0]          hit_b;
    logic [nfsp_pkg::IDX_W-1:0]          grant_idx;
    nfsp_pkg::cell_ctl_t                 ctl;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = ~busy;
    assign accept    = start & ~busy;

    assign done           = done_reg;
    assign slot_index     = slot_index_reg;
    assign overwrote_live = overwrote_reg;

    assign ctl.alloc_en = (state_reg == ST_GRANT);
    assign ctl.tick_en  = (state_reg == ST_TICK);
    assign ctl.dec      = dec_reg;

    assign found_a[0] = 1'b0;
    assign found_b[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < nfsp_pkg::SLOTS; gi++)
        begin : g_cell
            nfsp_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .grant       (grant_reg[gi]),
                .ge_start    (nfsp_pkg::IDX_W'(gi) >= search_start_reg),
                .found_a_in  (found_a[gi]),
                .found_b_in  (found_b[gi]),
                .found_a_out (found_a[gi+1]),
                .found_b_out (found_b[gi+1]),
                .hit_a       (hit_a[gi]),
                .hit_b       (hit_b[gi])
            );
        end
    endgenerate

    // Prefer the upper pass; fall back to the wrapped pass, then to slot 0
    always_comb
    begin
        over_next  = 1'b0;
        grant_next = '0;
        if (found_a[nfsp_pkg::SLOTS])
        begin
            grant_next = hit_a;
        end
        else if (found_b[nfsp_pkg::SLOTS])
        begin
            grant_next = hit_b;
        end
        else
        begin
            grant_next[0] = 1'b1;
            over_next     = 1'b1;
        end
    end

    always_comb
    begin
        grant_idx = '0;
        for (int i = 0; i < nfsp_pkg::SLOTS; i++)
        begin
            if (grant_reg[i])
            begin
                grant_idx = grant_idx | nfsp_pkg::IDX_W'(i);
            end
        end
    end

    assign product = nfsp_pkg::PROD_W'(decay_rate_reg) * nfsp_pkg::PROD_W'(tick_time);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req_type == nfsp_pkg::REQ_TICK) ? ST_TICK : ST_GRANT;
                end
            end
            ST_GRANT: state_next = ST_IDLE;
            ST_TICK:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            decay_rate_reg   <= nfsp_pkg::DECAY_RESET;
            search_start_reg <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_GRANT);
            if (cfg_valid && cfg_ready)
            begin
                decay_rate_reg <= cfg_data;
            end
            // Remember the granted slot unless the pool was full
            if (state_reg == ST_GRANT && !over_reg)
            begin
                search_start_reg <= grant_idx;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            grant_reg <= grant_next;
            over_reg  <= over_next;
            dec_reg   <= nfsp_pkg::DEC_W'(product >> nfsp_pkg::DEC_SHIFT);
        end
        if (state_reg == ST_GRANT)
        begin
            slot_index_reg <= nfsp_pkg::OUT_IDX_W'(grant_idx);
            overwrote_reg  <= over_reg;
        end
    end

    a_grant_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_GRANT |-> $onehot(grant_reg))
        else $error("grant vector not one-hot during grant");

    a_done_after_grant: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_GRANT |=> done_reg && !busy)
        else $error("result strobe missing after grant");

    a_over_slot0: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_GRANT && over_reg |-> grant_reg[0])
        else $error("full pool did not reuse slot 0");

    a_start_hold_on_over: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_GRANT && over_reg |=> $stable(search_start_reg))
        else $error("search start moved on overwrite");

endmodule

// ===== sim/nfsp_pool_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the next-fit slot pool: keeps a shadow of the slot lives and
// decay rate, predicts each allocate result and compares it. Depends on nfsp_pkg.
module nfsp_pool_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic                           req_type,
    input  logic [nfsp_pkg::TIME_W-1:0]    tick_time,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [nfsp_pkg::RATE_W-1:0]    cfg_data,
    input  logic                           done,
    input  logic [nfsp_pkg::OUT_IDX_W-1:0] slot_index,
    input  logic                           overwrote_live,
    output int                             mismatches,
    output int                             awaiting
);

    typedef struct packed {
        logic [nfsp_pkg::OUT_IDX_W-1:0] idx;
        logic                           over;
    } alloc_result_t;

    logic [nfsp_pkg::LIFE_W-1:0] life_shadow [nfsp_pkg::SLOTS];
    logic [nfsp_pkg::IDX_W-1:0]  next_fit_ptr;
    logic [nfsp_pkg::RATE_W-1:0] decay_shadow;
    alloc_result_t               expected_allocs [$];

    // Age every live slot, saturating at free.
    task automatic age_slots(input logic [nfsp_pkg::TIME_W-1:0] elapsed);
        logic [nfsp_pkg::PROD_W-1:0] prod;
        logic [nfsp_pkg::DEC_W-1:0]  dec;
        prod = nfsp_pkg::PROD_W'(decay_shadow) * nfsp_pkg::PROD_W'(elapsed);
        dec  = prod[nfsp_pkg::PROD_W-1:nfsp_pkg::DEC_SHIFT];
        for (int i = 0; i < nfsp_pkg::SLOTS; i++)
        begin
            if (life_shadow[i] != '0)
            begin
                if (nfsp_pkg::DEC_W'(life_shadow[i]) > dec)
                    life_shadow[i] = life_shadow[i] - dec[nfsp_pkg::LIFE_W-1:0];
                else
                    life_shadow[i] = '0;
            end
        end
    endtask

    // Search from the remembered index with wrap; fall back to slot 0 when full.
    task automatic allocate_slot();
        alloc_result_t res;
        int            pick;
        int            idx;
        logic          found;
        found = 1'b0;
        pick  = 0;
        for (int k = 0; k < nfsp_pkg::SLOTS; k++)
        begin
            idx = (int'(next_fit_ptr) + k) % nfsp_pkg::SLOTS;
            if (!found && life_shadow[idx] == '0)
            begin
                found = 1'b1;
                pick  = idx;
            end
        end
        if (found)
            next_fit_ptr = nfsp_pkg::IDX_W'(pick);
        life_shadow[pick] = nfsp_pkg::LIFE_FULL;
        res.idx  = nfsp_pkg::OUT_IDX_W'(pick);
        res.over = !found;
        expected_allocs.push_back(res);
    endtask

    always @(posedge clk)
    begin
        alloc_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < nfsp_pkg::SLOTS; i++)
                life_shadow[i] = '0;
            next_fit_ptr = '0;
            decay_shadow = nfsp_pkg::DECAY_RESET;
            expected_allocs.delete();
        end
        else
        begin
            // Results pass through the grant state and the done register after the request, so check before predicting.
            if (done)
            begin
                if (expected_allocs.size() == 0)
                begin
                    $error("unexpected result: slot_index %0d, overwrote_live %0d",
                           slot_index, overwrote_live);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = expected_allocs.pop_front();
                    if (slot_index !== want.idx)
                    begin
                        $error("slot_index mismatch: expected %0d, actual %0d",
                               want.idx, slot_index);
                        mismatches = mismatches + 1;
                    end
                    if (overwrote_live !== want.over)
                    begin
                        $error("overwrote_live mismatch: expected %0d, actual %0d",
                               want.over, overwrote_live);
                        mismatches = mismatches + 1;
                    end
                end
            end
            // A request taken on the same edge as a rate write still sees the old rate.
            if (start && !busy)
            begin
                if (req_type == nfsp_pkg::REQ_TICK)
                    age_slots(tick_time);
                else
                    allocate_slot();
            end
            if (cfg_valid && cfg_ready)
                decay_shadow = cfg_data;
        end
        awaiting = expected_allocs.size();
    end

endmodule

// ===== sim/next_fit_slot_pool_with_aging_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for next_fit_slot_pool_with_aging: drives directed and random
// allocate/tick requests and decay rate writes; checking is in nfsp_pool_checker.
module next_fit_slot_pool_with_aging_tb;

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    logic                            req_type;
    logic [nfsp_pkg::TIME_W-1:0]     tick_time;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [nfsp_pkg::RATE_W-1:0]     cfg_data;
    logic                            done;
    logic [nfsp_pkg::OUT_IDX_W-1:0]  slot_index;
    logic                            overwrote_live;
    int                              mismatches;
    int                              awaiting;

    next_fit_slot_pool_with_aging dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .tick_time      (tick_time),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .done           (done),
        .slot_index     (slot_index),
        .overwrote_live (overwrote_live)
    );

    nfsp_pool_checker scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .tick_time      (tick_time),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .done           (done),
        .slot_index     (slot_index),
        .overwrote_live (overwrote_live),
        .mismatches     (mismatches),
        .awaiting       (awaiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("next_fit_slot_pool_with_aging test failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [nfsp_pkg::TIME_W-1:0] pick_tick(input int tmax);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 10)
            return '1;
        if (r < 20)
            return nfsp_pkg::TIME_W'($urandom);
        return nfsp_pkg::TIME_W'($urandom_range(0, tmax));
    endfunction

    // Present one request and hold it until the block takes it.
    task automatic issue_request(input logic typ, input logic [nfsp_pkg::TIME_W-1:0] t);
        @(negedge clk);
        start     <= 1'b1;
        req_type  <= typ;
        tick_time <= t;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Drop start for a gap set by n, with junk on the request fields.
    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            start     <= 1'b0;
            req_type  <= 1'($urandom);
            tick_time <= nfsp_pkg::TIME_W'($urandom);
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Stop requests, wait for outstanding results, then let a tick finish.
    task automatic settle();
        int waited;
        @(negedge clk);
        start  <= 1'b0;
        waited = 0;
        while (awaiting != 0 && waited < 64)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_decay(input logic [nfsp_pkg::RATE_W-1:0] value);
        repeat ($urandom_range(0, 3)) @(negedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_data  <= nfsp_pkg::RATE_W'($urandom);
    endtask

    task automatic run_phase(input logic [nfsp_pkg::RATE_W-1:0] rate, input int alloc_pct,
                             input int tmax, input int count);
        logic typ;
        settle();
        write_decay(rate);
        for (int n = 0; n < count; n++)
        begin
            typ = ($urandom_range(0, 99) < alloc_pct) ? nfsp_pkg::REQ_ALLOC
                                                      : nfsp_pkg::REQ_TICK;
            issue_request(typ, pick_tick(tmax));
            // Keep some back-to-back stretches in every phase.
            if ((n % 80) < 20)
                idle_gap(0);
            else
                idle_gap(pick_gap());
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        req_type  = nfsp_pkg::REQ_ALLOC;
        tick_time = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Fresh pool: slots 0, 1, 2 in order; tick_time ignored on allocate.
        issue_request(nfsp_pkg::REQ_ALLOC, '1);
        issue_request(nfsp_pkg::REQ_ALLOC, '0);
        issue_request(nfsp_pkg::REQ_ALLOC, nfsp_pkg::TIME_W'($urandom));
        idle_gap(1);
        issue_request(nfsp_pkg::REQ_TICK, '0);
        issue_request(nfsp_pkg::REQ_TICK, nfsp_pkg::TIME_W'(1));
        settle();
        write_decay('0);
        issue_request(nfsp_pkg::REQ_TICK, '1);
        issue_request(nfsp_pkg::REQ_ALLOC, '0);
        // Largest decrement frees every slot.
        settle();
        write_decay('1);
        issue_request(nfsp_pkg::REQ_TICK, '1);
        issue_request(nfsp_pkg::REQ_ALLOC, '0);
        issue_request(nfsp_pkg::REQ_ALLOC, '0);
        // Decrement equal to full life.
        issue_request(nfsp_pkg::REQ_TICK, nfsp_pkg::TIME_W'(16'h0100));
        issue_request(nfsp_pkg::REQ_ALLOC, '0);
        settle();
        write_decay(nfsp_pkg::RATE_W'(1));
        issue_request(nfsp_pkg::REQ_TICK, nfsp_pkg::TIME_W'(16'h00ff));
        issue_request(nfsp_pkg::REQ_TICK, nfsp_pkg::TIME_W'(16'h0100));
        issue_request(nfsp_pkg::REQ_TICK, nfsp_pkg::TIME_W'(16'h8000));
        issue_request(nfsp_pkg::REQ_ALLOC, '1);

        run_phase('0, 85, 16'hffff, 280);
        run_phase(nfsp_pkg::RATE_W'(256), 70, 3000, 280);
        run_phase('1, 80, 8, 280);
        run_phase(nfsp_pkg::RATE_W'(1), 90, 16'hffff, 280);
        run_phase(nfsp_pkg::RATE_W'($urandom), 60, $urandom_range(1, 65535), 280);
        run_phase(nfsp_pkg::RATE_W'(4096), 75, 64, 280);

        settle();
        repeat (8) @(negedge clk);
        if (awaiting != 0)
            $error("results still expected at end: %0d", awaiting);
        if (mismatches == 0 && awaiting == 0)
            $display("next_fit_slot_pool_with_aging test passed");
        else
            $display("next_fit_slot_pool_with_aging test failed");
        $finish;
    end

endmodule
